// File: rtl/grid_multisource_bfs_levels_unit_macros.svh
// assertion macros used by the checker file
`ifndef GRID_MULTISOURCE_BFS_LEVELS_UNIT_MACROS_SVH
`define GRID_MULTISOURCE_BFS_LEVELS_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define GMBL_CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gmbl check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define GMBL_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gmbl check failed");

`endif

// File: rtl/gmbl_pkg.sv
// types, constants and helper functions for the grid breadth-first level unit
package gmbl_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;

  localparam int DIM_W   = 5;
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W   = ADDR_W + 1;
  localparam int LVL_W   = ADDR_W;
  localparam int LEVEL_OUT_W = 8;
  localparam int CFG_IDX_W   = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  // cell markings
  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_OPEN  = 2'd1;
  localparam logic [1:0] CELL_SEED  = 2'd2;
  localparam logic [1:0] CELL_ODD   = 2'd3;

  typedef struct packed {
    logic [1:0] cell_state;
    logic       last_cell;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_OUT_W-1:0] max_level;
    logic                   unreached;
  } out_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [LVL_W-1:0] level;
  } q_entry_t;

  typedef struct packed {
    logic     clear;
    logic     push;
    logic     pop;
    q_entry_t push_entry;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
  } q_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int max);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (int'(v) > max) r = DIM_W'(max);
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] cell_count(input logic [DIM_W-1:0] rows,
                                                  input logic [DIM_W-1:0] cols);
    return CNT_W'(CNT_W'(rows) * CNT_W'(cols));
  endfunction

  function automatic logic [LEVEL_OUT_W-1:0] sat_level(input logic [LVL_W-1:0] d);
    logic [LEVEL_OUT_W-1:0] r;
    if (int'(d) > 255) r = LEVEL_OUT_W'(255);
    else r = LEVEL_OUT_W'(d);
    return r;
  endfunction

endpackage

// File: rtl/gmbl_queue.sv
// frontier queue: one synchronous memory with head and tail pointers
module gmbl_queue (
  input  logic               clk,
  input  logic               rst,
  input  gmbl_pkg::q_ctrl_t  ctrl,
  output gmbl_pkg::q_entry_t rd_entry,
  output gmbl_pkg::q_stat_t  status
);

  gmbl_pkg::q_entry_t mem [gmbl_pkg::CELLS];
  logic [gmbl_pkg::CNT_W-1:0] head;
  logic [gmbl_pkg::CNT_W-1:0] tail;

  assign status.empty = (head == tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (ctrl.clear) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (ctrl.push) tail <= tail + gmbl_pkg::CNT_W'(1);
      if (ctrl.pop) head <= head + gmbl_pkg::CNT_W'(1);
    end
  end

  // each cell enters at most once, so the tail never wraps
  always_ff @(posedge clk) begin
    if (ctrl.push) mem[tail[gmbl_pkg::ADDR_W-1:0]] <= ctrl.push_entry;
    if (ctrl.pop) rd_entry <= mem[head[gmbl_pkg::ADDR_W-1:0]];
  end

endmodule

// File: rtl/grid_multisource_bfs_levels_unit.sv
// top level: grid loader, seed scan and breadth-first walk over the cell store
// Cells are taken one per cycle in row-major order; the item with last_cell set starts the
// walk, and no cell is taken until its result has been formed. The walk first scans all
// rows*cols cells through the cell store read port, queueing seeds and counting open
// cells, then handles each queued cell with one queue read and four neighbour reads through
// the single read port of the cell store, the last check overlapping the next queue read,
// plus a pass through the pop state when the queue runs dry. The result is then placed in
// the output register, and the next grid can load while it waits to be taken. Entries at
// or beyond the number of cells loaded read as empty, so no clearing pass is needed.
module grid_multisource_bfs_levels_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gmbl_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gmbl_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gmbl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gmbl_pkg::DIM_W-1:0]          cfg_data
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_POP   = 3'd2;
  localparam logic [2:0] ST_NBR   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  logic [2:0] state;
  logic [1:0] dir;

  logic [gmbl_pkg::DIM_W-1:0] rows;
  logic [gmbl_pkg::DIM_W-1:0] cols;
  logic [gmbl_pkg::CNT_W-1:0] load_pos;
  logic [gmbl_pkg::CNT_W-1:0] load_total;
  logic [gmbl_pkg::CNT_W-1:0] total;

  logic [gmbl_pkg::CNT_W-1:0] scan_idx;
  logic [gmbl_pkg::ROW_W-1:0] scan_row;
  logic [gmbl_pkg::COL_W-1:0] scan_col;

  // read pipeline stage: address issued last cycle, data in c_rdata now
  logic                        p_valid;
  logic [gmbl_pkg::ADDR_W-1:0] p_addr;
  logic [gmbl_pkg::ROW_W-1:0]  p_row;
  logic [gmbl_pkg::COL_W-1:0]  p_col;
  logic [gmbl_pkg::LVL_W-1:0]  p_lvl;

  logic [gmbl_pkg::LVL_W-1:0] deepest;
  logic [gmbl_pkg::CNT_W-1:0] open_cnt;
  logic [gmbl_pkg::CNT_W-1:0] reached_cnt;

  logic [1:0] cmem [gmbl_pkg::CELLS];
  logic [1:0] c_rdata;
  logic       c_we;
  logic [gmbl_pkg::ADDR_W-1:0] c_waddr;
  logic [1:0] c_wdata;
  logic       c_re;
  logic [gmbl_pkg::ADDR_W-1:0] c_raddr;

  gmbl_pkg::q_ctrl_t  q_ctrl;
  gmbl_pkg::q_entry_t q_rd;
  gmbl_pkg::q_stat_t  q_stat;

  logic                        in_fire;
  logic                        load_store;
  logic [1:0]                  cell_rd;
  logic                        chk_seed;
  logic                        chk_open;
  logic                        chk_hit;
  logic                        scan_issue;
  logic                        nb_ok;
  logic [gmbl_pkg::ROW_W-1:0]  nb_row;
  logic [gmbl_pkg::COL_W-1:0]  nb_col;
  logic [gmbl_pkg::ADDR_W-1:0] nb_addr;
  logic                        out_load;

  gmbl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (q_ctrl),
    .rd_entry (q_rd),
    .status   (q_stat)
  );

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == ST_LOAD);
  assign in_fire    = in_valid && in_ready;
  assign load_total = gmbl_pkg::cell_count(rows, cols);
  assign load_store = in_fire && (load_pos < load_total);
  assign scan_issue = (state == ST_SCAN) && (scan_idx != total);
  assign out_load   = (state == ST_DONE) && (!out_valid || out_ready);

  // entries past the fill point belong to an earlier grid
  assign cell_rd  = ({1'b0, p_addr} < load_pos) ? c_rdata : gmbl_pkg::CELL_EMPTY;
  assign chk_seed = p_valid && (state == ST_SCAN) && (cell_rd == gmbl_pkg::CELL_SEED);
  assign chk_open = p_valid && (state == ST_SCAN) && (cell_rd == gmbl_pkg::CELL_OPEN);
  assign chk_hit  = p_valid && ((state == ST_NBR) || (state == ST_DRAIN)) &&
                    (cell_rd == gmbl_pkg::CELL_OPEN);

  // neighbour of the cell at the queue head
  always_comb begin
    nb_row = q_rd.row;
    nb_col = q_rd.col;
    nb_ok  = 1'b0;
    case (dir)
      DIR_UP: begin
        nb_ok  = (q_rd.row != '0);
        nb_row = q_rd.row - gmbl_pkg::ROW_W'(1);
      end
      DIR_LEFT: begin
        nb_ok  = (q_rd.col != '0);
        nb_col = q_rd.col - gmbl_pkg::COL_W'(1);
      end
      DIR_RIGHT: begin
        nb_ok  = ((gmbl_pkg::DIM_W'(q_rd.col) + gmbl_pkg::DIM_W'(1)) < cols);
        nb_col = q_rd.col + gmbl_pkg::COL_W'(1);
      end
      DIR_DOWN: begin
        nb_ok  = ((gmbl_pkg::DIM_W'(q_rd.row) + gmbl_pkg::DIM_W'(1)) < rows);
        nb_row = q_rd.row + gmbl_pkg::ROW_W'(1);
      end
      default: nb_ok = 1'b0;
    endcase
    nb_addr = gmbl_pkg::ADDR_W'(gmbl_pkg::ADDR_W'(nb_row) * gmbl_pkg::ADDR_W'(cols)
                                + gmbl_pkg::ADDR_W'(nb_col));
  end

  always_comb begin
    c_we    = 1'b0;
    c_waddr = p_addr;
    c_wdata = gmbl_pkg::CELL_SEED;
    if (load_store) begin
      c_we    = 1'b1;
      c_waddr = load_pos[gmbl_pkg::ADDR_W-1:0];
      c_wdata = (in_data.cell_state == gmbl_pkg::CELL_ODD) ? gmbl_pkg::CELL_EMPTY
                                                          : in_data.cell_state;
    end else if (chk_hit) begin
      c_we = 1'b1;
    end
    c_re    = scan_issue || ((state == ST_NBR) && nb_ok);
    c_raddr = (state == ST_SCAN) ? scan_idx[gmbl_pkg::ADDR_W-1:0] : nb_addr;
  end

  always_comb begin
    q_ctrl.clear           = in_fire && in_data.last_cell;
    q_ctrl.push            = chk_seed || chk_hit;
    q_ctrl.push_entry.row   = p_row;
    q_ctrl.push_entry.col   = p_col;
    q_ctrl.push_entry.level = p_lvl;
    q_ctrl.pop             = ((state == ST_POP) || (state == ST_DRAIN)) && !q_stat.empty;
  end

  always_ff @(posedge clk) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    if (c_re) c_rdata <= cmem[c_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= gmbl_pkg::DIM_W'(1);
      cols <= gmbl_pkg::DIM_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        gmbl_pkg::REG_ROWS: rows <= gmbl_pkg::clamp_dim(cfg_data, gmbl_pkg::MAX_ROWS);
        gmbl_pkg::REG_COLS: cols <= gmbl_pkg::clamp_dim(cfg_data, gmbl_pkg::MAX_COLS);
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      dir      <= DIR_UP;
      load_pos <= '0;
      p_valid  <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (load_store) load_pos <= load_pos + gmbl_pkg::CNT_W'(1);
          if (in_fire && in_data.last_cell) state <= ST_SCAN;
        end
        ST_SCAN: begin
          p_valid <= scan_issue;
          if (!scan_issue && !p_valid) state <= ST_POP;
        end
        ST_POP: begin
          dir <= DIR_UP;
          if (q_stat.empty) state <= ST_DONE;
          else state <= ST_NBR;
        end
        ST_NBR: begin
          p_valid <= nb_ok;
          dir     <= dir + 2'd1;
          if (dir == DIR_DOWN) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          p_valid <= 1'b0;
          dir     <= DIR_UP;
          if (q_stat.empty) state <= ST_POP;
          else state <= ST_NBR;
        end
        ST_DONE: begin
          if (out_load) begin
            load_pos <= '0;
            state    <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (in_fire && in_data.last_cell) begin
      total       <= load_total;
      scan_idx    <= '0;
      scan_row    <= '0;
      scan_col    <= '0;
      deepest     <= '0;
      open_cnt    <= '0;
      reached_cnt <= '0;
    end else begin
      if (scan_issue) begin
        p_addr   <= scan_idx[gmbl_pkg::ADDR_W-1:0];
        p_row    <= scan_row;
        p_col    <= scan_col;
        p_lvl    <= '0;
        scan_idx <= scan_idx + gmbl_pkg::CNT_W'(1);
        if ((gmbl_pkg::DIM_W'(scan_col) + gmbl_pkg::DIM_W'(1)) == cols) begin
          scan_col <= '0;
          scan_row <= scan_row + gmbl_pkg::ROW_W'(1);
        end else begin
          scan_col <= scan_col + gmbl_pkg::COL_W'(1);
        end
      end
      if (state == ST_NBR) begin
        p_addr <= nb_addr;
        p_row  <= nb_row;
        p_col  <= nb_col;
        p_lvl  <= q_rd.level + gmbl_pkg::LVL_W'(1);
        if (q_rd.level > deepest) deepest <= q_rd.level;
      end
      if (chk_open) open_cnt <= open_cnt + gmbl_pkg::CNT_W'(1);
      if (chk_hit) reached_cnt <= reached_cnt + gmbl_pkg::CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.max_level <= gmbl_pkg::sat_level(deepest);
      out_data.unreached <= (open_cnt != reached_cnt);
    end
  end

endmodule

// File: rtl/gmbl_checker.sv
// port-level checks on the grid breadth-first level unit, bound to its top level
`include "grid_multisource_bfs_levels_unit_macros.svh"

module gmbl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input gmbl_pkg::in_item_t             in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input gmbl_pkg::out_item_t            out_data,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [gmbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [gmbl_pkg::DIM_W-1:0]     cfg_data
);

  logic last_fire;
  logic cfg_fire;

  assign last_fire = in_valid && in_ready && in_data.last_cell;
  assign cfg_fire  = cfg_valid && cfg_ready && (cfg_index == gmbl_pkg::REG_ROWS) &&
                     (cfg_data == '0);

  // a waiting result holds
  `GMBL_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // the last cell closes the input until the walk ends
  `GMBL_CHECK_NEXT(a_walk_blocks_input, last_fire, !in_ready)
  // a result appears only at the end of a walk
  `GMBL_CHECK_NOW(a_result_after_walk, $rose(out_valid), $past(!in_ready) && in_ready)
  // configuration is always taken
  `GMBL_CHECK_NOW(a_cfg_taken, cfg_fire || cfg_valid, cfg_ready)

endmodule

bind grid_multisource_bfs_levels_unit gmbl_checker u_gmbl_checker (.*);
